// ===== src/srig_pkg.sv =====
// Shared widths, codes and types for the slice resample index generator.
package srig_pkg;

    localparam int IDX_W      = 20;
    localparam int TOTAL_W    = 20;
    localparam int SLICE_W    = 12;
    localparam int SRC_W      = 13;
    localparam int RATIO_W    = 24;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 24;
    localparam int STATUS_W   = 2;

    localparam int DEF_MAX_SLICES      = 4096;
    localparam int DEF_RATIO_FRAC_BITS = 16;
    localparam int DEF_WEIGHT_BITS     = 16;

    localparam int DIV_STEPS_PER_STAGE = 4;
    localparam int SETTLE_CYCLES       = 3;

    localparam logic [TOTAL_W-1:0] TOTAL_MAX = {TOTAL_W{1'b1}};

    localparam logic [CFG_IDX_W-1:0] REG_SOURCE_COUNT  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_STRETCH_RATIO = CFG_IDX_W'(1);

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_RATIO_LOW = 2'd1,
        ST_RANGE     = 2'd2
    } t_status;

    typedef struct packed {
        logic                 valid;
        t_status              status;
    } t_ctl;

    typedef struct packed {
        logic [TOTAL_W-1:0]   total;
        logic [SRC_W-1:0]     src_int;
        logic [TOTAL_W-1:0]   out_int;
        logic                 ratio_low;
        logic                 single;
        logic                 busy;
    } t_cfg_derived;

endpackage

// ===== src/srig_cfg.sv =====
// Configuration registers and derivation of the output slice count.
module srig_cfg #(
    parameter int MAX_SLICES      = srig_pkg::DEF_MAX_SLICES,
    parameter int RATIO_FRAC_BITS = srig_pkg::DEF_RATIO_FRAC_BITS
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [srig_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [srig_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    output srig_pkg::t_cfg_derived            o_derived
);
    import srig_pkg::*;

    localparam int PROD_W  = SRC_W + RATIO_W;
    localparam int WHOLE_W = PROD_W - RATIO_FRAC_BITS;
    localparam logic [31:0] MAX_L = 32'(MAX_SLICES);
    localparam logic [RATIO_FRAC_BITS-1:0] HALF =
        RATIO_FRAC_BITS'(1) << (RATIO_FRAC_BITS - 1);
    localparam logic [RATIO_W:0] ONE_RATIO = (RATIO_W + 1)'(1) << RATIO_FRAC_BITS;
    localparam int SETTLE_W = $clog2(SETTLE_CYCLES + 1);

    logic [SRC_W-1:0]   r_src;
    logic [RATIO_W-1:0] r_ratio;
    logic [SETTLE_W-1:0] r_settle;
    logic [SETTLE_W-1:0] n_settle;

    logic [SRC_W-1:0]   r_s_eff;
    logic [PROD_W-1:0]  r_prod;
    logic               r_ratio_low_a;
    logic [TOTAL_W-1:0] r_total;
    logic [SRC_W-1:0]   r_src_int;
    logic               r_ratio_low;
    logic [TOTAL_W-1:0] r_out_int;
    logic               r_single;

    logic [SRC_W-1:0]   w_s_eff;
    logic [SRC_W-1:0]   w_s_m1;
    logic [WHOLE_W-1:0] w_whole;
    logic [RATIO_FRAC_BITS-1:0] w_frac;
    logic               w_rnd;
    logic [WHOLE_W:0]   w_t;
    logic [TOTAL_W-1:0] w_total;
    logic               w_cfg_acc;

    assign o_cfg_ready = 1'b1;
    assign w_cfg_acc   = i_cfg_valid;

    always_comb begin
        if (w_cfg_acc) begin
            n_settle = SETTLE_W'(SETTLE_CYCLES);
        end else if (r_settle != '0) begin
            n_settle = r_settle - SETTLE_W'(1);
        end else begin
            n_settle = r_settle;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_src    <= '0;
            r_ratio  <= RATIO_W'(ONE_RATIO);
            r_settle <= SETTLE_W'(SETTLE_CYCLES);
        end else begin
            r_settle <= n_settle;
            if (w_cfg_acc) begin
                unique case (i_cfg_index)
                    REG_SOURCE_COUNT:  r_src   <= i_cfg_data[SRC_W-1:0];
                    REG_STRETCH_RATIO: r_ratio <= i_cfg_data[RATIO_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    assign w_s_eff = (32'(r_src) > MAX_L) ? MAX_L[SRC_W-1:0] : r_src;
    assign w_s_m1  = r_s_eff - SRC_W'(1);
    assign w_whole = r_prod[PROD_W-1:RATIO_FRAC_BITS];
    assign w_frac  = r_prod[RATIO_FRAC_BITS-1:0];
    assign w_rnd   = (w_frac > HALF) || ((w_frac == HALF) && w_whole[0]);
    assign w_t     = {1'b0, w_whole} + (WHOLE_W + 1)'(w_rnd) + (WHOLE_W + 1)'(1);

    always_comb begin
        if (r_s_eff <= SRC_W'(1)) begin
            w_total = TOTAL_W'(r_s_eff);
        end else if (32'(w_t) > 32'(TOTAL_MAX)) begin
            w_total = TOTAL_MAX;
        end else begin
            w_total = TOTAL_W'(w_t);
        end
    end

    // derived values are recomputed every cycle and settle after a write
    always_ff @(posedge i_clk) begin
        r_s_eff       <= w_s_eff;
        r_prod        <= PROD_W'(w_s_m1) * PROD_W'(r_ratio);
        r_ratio_low_a <= {1'b0, r_ratio} < ONE_RATIO;
        r_total       <= w_total;
        r_src_int     <= w_s_m1;
        r_ratio_low   <= r_ratio_low_a;
        r_out_int     <= r_total - TOTAL_W'(1);
        r_single      <= r_total == TOTAL_W'(1);
    end

    assign o_derived.total     = r_total;
    assign o_derived.src_int   = r_src_int;
    assign o_derived.out_int   = r_out_int;
    assign o_derived.ratio_low = r_ratio_low;
    assign o_derived.single    = r_single;
    assign o_derived.busy      = r_settle != '0;

endmodule

// ===== src/srig_div_stage.sv =====
// One pipeline stage of the restoring divider: a few quotient bits per stage.
module srig_div_stage #(
    parameter int DIV_W = srig_pkg::TOTAL_W,
    parameter int QUO_W = srig_pkg::SRC_W + srig_pkg::DEF_WEIGHT_BITS,
    parameter int STEPS = srig_pkg::DIV_STEPS_PER_STAGE
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_en,
    input  logic [DIV_W-1:0]      i_divisor,
    input  srig_pkg::t_ctl        i_ctl,
    input  logic [DIV_W-1:0]      i_rem,
    input  logic [QUO_W-1:0]      i_quo,
    output srig_pkg::t_ctl        o_ctl,
    output logic [DIV_W-1:0]      o_rem,
    output logic [QUO_W-1:0]      o_quo
);
    import srig_pkg::*;

    t_ctl              r_ctl;
    logic [DIV_W-1:0]  r_rem;
    logic [QUO_W-1:0]  r_quo;
    logic [DIV_W-1:0]  n_rem;
    logic [QUO_W-1:0]  n_quo;

    always_comb begin
        logic [DIV_W:0] trial;
        n_rem = i_rem;
        n_quo = i_quo;
        trial = '0;
        for (int j = 0; j < STEPS; j++) begin
            trial = {n_rem, n_quo[QUO_W-1]};
            n_quo = {n_quo[QUO_W-2:0], 1'b0};
            if (trial >= {1'b0, i_divisor}) begin
                trial    = trial - {1'b0, i_divisor};
                n_quo[0] = 1'b1;
            end
            n_rem = trial[DIV_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl.valid <= 1'b0;
        end else if (i_en) begin
            r_ctl.valid <= i_ctl.valid;
        end
        if (i_en) begin
            r_ctl.status <= i_ctl.status;
            r_rem        <= n_rem;
            r_quo        <= n_quo;
        end
    end

    assign o_ctl = r_ctl;
    assign o_rem = r_rem;
    assign o_quo = r_quo;

endmodule

// ===== src/slice_resample_index_generator_unit.sv =====
// Top level of the slice resample index generator.
// Throughput: one item per cycle unless the output stalls on i_ready or the derived slice count
// settles; each divider stage resolves up to four quotient bits.
// Reset (synchronous, active low) sets 0 source slices and a ratio of 1.0.
// Input ready drops after reset and after each configuration write
// while the derived slice count settles.
module slice_resample_index_generator_unit #(
    parameter int MAX_SLICES      = srig_pkg::DEF_MAX_SLICES,
    parameter int RATIO_FRAC_BITS = srig_pkg::DEF_RATIO_FRAC_BITS,
    parameter int WEIGHT_BITS     = srig_pkg::DEF_WEIGHT_BITS
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [srig_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [srig_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  logic                              i_valid,
    output logic                              o_ready,
    input  logic [srig_pkg::IDX_W-1:0]        i_output_index,
    output logic                              o_valid,
    input  logic                              i_ready,
    output logic [srig_pkg::TOTAL_W-1:0]      o_slice_total,
    output logic [srig_pkg::SLICE_W-1:0]      o_lower_slice,
    output logic [srig_pkg::SLICE_W-1:0]      o_upper_slice,
    output logic [WEIGHT_BITS-1:0]            o_blend_weight,
    output logic                              o_copy_only,
    output logic [srig_pkg::STATUS_W-1:0]     o_status
);
    import srig_pkg::*;

    localparam int QUO_W = SRC_W + WEIGHT_BITS;
    localparam int NUM_W = IDX_W + SRC_W;
    localparam int DIV_W = TOTAL_W;
    localparam int SPS   = DIV_STEPS_PER_STAGE;
    localparam int NDS   = (QUO_W + SPS - 1) / SPS;

    t_cfg_derived      w_cfg;

    logic              r_v0;
    logic [IDX_W-1:0]  r_idx;
    logic              w_en_entry;
    logic              w_en_mult;

    t_ctl              r_ctl1;
    logic [NUM_W-1:0]  r_num;
    t_status           w_status1;

    t_ctl              w_ctl [0:NDS];
    logic [DIV_W-1:0]  w_rem [0:NDS];
    logic [QUO_W-1:0]  w_quo [0:NDS];
    logic              w_en  [0:NDS];

    logic              r_o_valid;
    logic [TOTAL_W-1:0] r_total;
    logic [SLICE_W-1:0] r_lower;
    logic [SLICE_W-1:0] r_upper;
    logic [WEIGHT_BITS-1:0] r_weight;
    logic              r_copy;
    t_status           r_status;

    logic [SRC_W-1:0]  w_q_int;
    logic [SRC_W:0]    w_q_inc;
    logic [SRC_W-1:0]  w_upper;
    logic [WEIGHT_BITS-1:0] w_weight;
    logic              w_copy;

    srig_cfg #(
        .MAX_SLICES      (MAX_SLICES),
        .RATIO_FRAC_BITS (RATIO_FRAC_BITS)
    ) u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_derived   (w_cfg)
    );

    // stage enables: a stage moves when it is empty or the next one moves
    assign w_en[NDS]  = !r_o_valid || i_ready;
    assign w_en_mult  = !w_ctl[0].valid || w_en[0];
    assign w_en_entry = !r_v0 || w_en_mult;
    assign o_ready    = w_en_entry && !w_cfg.busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
        end else if (w_en_entry) begin
            r_v0 <= i_valid && o_ready;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en_entry) begin
            r_idx <= i_output_index;
        end
    end

    always_comb begin
        if (w_cfg.ratio_low) begin
            w_status1 = ST_RATIO_LOW;
        end else if (r_idx >= w_cfg.total) begin
            w_status1 = ST_RANGE;
        end else begin
            w_status1 = ST_OK;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl1.valid <= 1'b0;
        end else if (w_en_mult) begin
            r_ctl1.valid <= r_v0;
        end
        if (w_en_mult) begin
            r_ctl1.status <= w_status1;
            r_num         <= NUM_W'(r_idx) * NUM_W'(w_cfg.src_int);
        end
    end

    // dividend is num << WEIGHT_BITS; its top part is already below the divisor
    assign w_ctl[0] = r_ctl1;
    assign w_rem[0] = r_num[NUM_W-1:SRC_W];
    assign w_quo[0] = {r_num[SRC_W-1:0], WEIGHT_BITS'(0)};

    for (genvar k = 0; k < NDS; k++) begin : g_div
        localparam int STEPS = (QUO_W - k * SPS < SPS) ? (QUO_W - k * SPS) : SPS;

        assign w_en[k] = !w_ctl[k+1].valid || w_en[k+1];

        srig_div_stage #(
            .DIV_W (DIV_W),
            .QUO_W (QUO_W),
            .STEPS (STEPS)
        ) u_stage (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_en      (w_en[k]),
            .i_divisor (w_cfg.out_int),
            .i_ctl     (w_ctl[k]),
            .i_rem     (w_rem[k]),
            .i_quo     (w_quo[k]),
            .o_ctl     (w_ctl[k+1]),
            .o_rem     (w_rem[k+1]),
            .o_quo     (w_quo[k+1])
        );
    end

    assign w_q_int  = w_quo[NDS][QUO_W-1:WEIGHT_BITS];
    assign w_weight = w_quo[NDS][WEIGHT_BITS-1:0];
    assign w_q_inc  = {1'b0, w_q_int} + (SRC_W + 1)'(1);
    assign w_upper  = (w_q_inc < {1'b0, w_cfg.src_int}) ? w_q_inc[SRC_W-1:0] : w_cfg.src_int;
    assign w_copy   = (w_upper == w_q_int) || (w_weight == '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (w_en[NDS]) begin
            r_o_valid <= w_ctl[NDS].valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en[NDS]) begin
            r_status <= w_ctl[NDS].status;
            r_total  <= (w_ctl[NDS].status == ST_RATIO_LOW) ? '0 : w_cfg.total;
            if (w_ctl[NDS].status != ST_OK) begin
                r_lower  <= '0;
                r_upper  <= '0;
                r_weight <= '0;
                r_copy   <= 1'b0;
            end else if (w_cfg.single) begin
                r_lower  <= '0;
                r_upper  <= '0;
                r_weight <= '0;
                r_copy   <= 1'b1;
            end else begin
                r_lower  <= w_q_int[SLICE_W-1:0];
                r_upper  <= w_upper[SLICE_W-1:0];
                r_weight <= w_weight;
                r_copy   <= w_copy;
            end
        end
    end

    assign o_valid        = r_o_valid;
    assign o_slice_total  = r_total;
    assign o_lower_slice  = r_lower;
    assign o_upper_slice  = r_upper;
    assign o_blend_weight = r_weight;
    assign o_copy_only    = r_copy;
    assign o_status       = r_status;

`ifndef SYNTHESIS
    a_settle_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cfg.busy |-> !o_ready)
        else $error("item accepted while derived count settles");

    a_ratio_low_zeros: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_status == ST_RATIO_LOW)) |->
        ((o_slice_total == '0) && (o_lower_slice == '0) && (o_blend_weight == '0)
         && !o_copy_only))
        else $error("ratio below one with non-zero result fields");

    a_range_zeros: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_status == ST_RANGE)) |->
        ((o_lower_slice == '0) && (o_upper_slice == '0) && (o_blend_weight == '0)
         && !o_copy_only))
        else $error("out of range item with non-zero slice fields");

    a_div_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_ctl[NDS].valid && (w_ctl[NDS].status == ST_OK) && !w_cfg.single) |->
        (w_rem[NDS] < w_cfg.out_int))
        else $error("divider remainder not below divisor");
`endif

endmodule
